// File: sv/mpt_pkg.sv
// Shared types and constants for the multi-turn position tracker.
// Holds the sequencer state type, mode and register codes, and the combine helper.
// No dependencies.
`default_nettype none

package mpt_pkg;

  localparam int POS_W  = 16;
  localparam int COMB_W = 32;
  localparam int PCT_W  = 14;
  localparam int NUM_W  = COMB_W + PCT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_COMBINE,
    ST_ORDER,
    ST_OFFSET,
    ST_SCALE,
    ST_DIVIDE,
    ST_FINISH
  } mpt_state_e;

  localparam logic [1:0] MODE_SAMPLE     = 2'd0;
  localparam logic [1:0] MODE_ACTIVATE   = 2'd1;
  localparam logic [1:0] MODE_DEACTIVATE = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_VALUE_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_VALUE_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_TURN_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_TURN_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HYSTERESIS = 3'd5;

  localparam logic [POS_W-1:0] UNCAL_VALUE = 16'hFFFF;
  localparam logic [POS_W-1:0] UNCAL_TURN  = 16'h0020;
  localparam logic [PCT_W-1:0] PCT_FULL    = 14'd10000;

  localparam logic [POS_W-1:0] RST_WRAP_THRESHOLD   = 16'd2048;
  localparam logic [POS_W-1:0] RST_BLINK_HYSTERESIS = 16'd64;

  typedef struct packed {
    logic [POS_W-1:0] cal_value_min;
    logic [POS_W-1:0] cal_value_max;
    logic [POS_W-1:0] cal_turn_min;
    logic [POS_W-1:0] cal_turn_max;
    logic [POS_W-1:0] wrap_threshold;
    logic [POS_W-1:0] blink_hysteresis;
  } mpt_cfg_t;

  typedef struct packed {
    logic upd;
    logic chk;
  } mpt_trk_ctl_t;

  // turn * counts-per-turn + pos, modulo 2^32; tc is a constant at every call
  function automatic logic [COMB_W-1:0] combine(input logic [POS_W-1:0] turn,
                                                input logic [POS_W-1:0] pos,
                                                input logic [POS_W:0]   tc);
    logic [2*POS_W:0] prod;
    prod = {{(POS_W+1){1'b0}}, turn} * {{POS_W{1'b0}}, tc};
    return prod[COMB_W-1:0] + {{(COMB_W-POS_W){1'b0}}, pos};
  endfunction

endpackage

`default_nettype wire

// File: sv/mpt_divider.sv
// Bit-serial restoring divider producing a PCT_W-bit quotient, one bit per cycle.
// Depends on mpt_pkg for widths.
`default_nettype none

module mpt_divider (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [mpt_pkg::NUM_W-1:0]  num_i,
  input  wire logic [mpt_pkg::COMB_W-1:0] den_i,
  output logic                            busy_o,
  output logic [mpt_pkg::PCT_W-1:0]       quot_o
);

  localparam int CNT_W = $clog2(mpt_pkg::PCT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mpt_pkg::PCT_W - 1);

  logic [mpt_pkg::COMB_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [mpt_pkg::PCT_W-1:0]  shr_q, shr_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic [mpt_pkg::COMB_W:0]   trial, diffv;
  logic                       ge;

  // Shift in the next numerator bit, subtract when it fits
  assign trial = {rem_q, shr_q[mpt_pkg::PCT_W-1]};
  assign diffv = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    shr_d  = shr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = num_i[mpt_pkg::NUM_W-1:mpt_pkg::PCT_W];
      shr_d  = num_i[mpt_pkg::PCT_W-1:0];
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diffv[mpt_pkg::COMB_W-1:0] : trial[mpt_pkg::COMB_W-1:0];
      shr_d = {shr_q[mpt_pkg::PCT_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    shr_q <= shr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = shr_q;

endmodule

`default_nettype wire

// File: sv/mpt_tracker.sv
// Turn tracking state: position, turn counter, init flag and zero-crossing indicator.
// Depends on mpt_pkg.
`default_nettype none

module mpt_tracker #(
  parameter int TURN_COUNTS = 4096
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire mpt_pkg::mpt_trk_ctl_t      ctl_i,
  input  wire mpt_pkg::mpt_cfg_t          cfg_i,
  input  wire logic [1:0]                 mode_i,
  input  wire logic [mpt_pkg::POS_W-1:0]  sample_i,
  input  wire logic [mpt_pkg::COMB_W-1:0] cur_comb_i,
  output logic [mpt_pkg::POS_W-1:0]       pos_o,
  output logic [mpt_pkg::POS_W-1:0]       turn_o,
  output logic                            blink_o
);

  localparam logic [mpt_pkg::POS_W:0] TC = (mpt_pkg::POS_W+1)'(TURN_COUNTS);

  logic [mpt_pkg::POS_W-1:0]  pos_q, pos_d, turn_q, turn_d;
  logic                       init_q, init_d, upward_q, upward_d;
  logic                       arm_q, arm_d, blink_q, blink_d;
  logic [mpt_pkg::COMB_W-1:0] ref_q, ref_d, moved;
  logic [mpt_pkg::POS_W-1:0]  delta, dmin, dmax, init_turn;
  logic                       up, wrap, fire;

  assign up    = (sample_i > pos_q);
  assign delta = up ? (sample_i - pos_q) : (pos_q - sample_i);
  assign wrap  = (delta >= cfg_i.wrap_threshold);

  // Turn after (re)initialization: UNCAL_TURN if uncalibrated, else a calibrated end, nearest as fallback
  always_comb begin
    dmin = (sample_i >= cfg_i.cal_value_min) ? (sample_i - cfg_i.cal_value_min)
                                             : (cfg_i.cal_value_min - sample_i);
    dmax = (sample_i >= cfg_i.cal_value_max) ? (sample_i - cfg_i.cal_value_max)
                                             : (cfg_i.cal_value_max - sample_i);
    init_turn = (dmin < dmax) ? cfg_i.cal_turn_min : cfg_i.cal_turn_max;
    if (cfg_i.cal_value_min == mpt_pkg::UNCAL_VALUE ||
        cfg_i.cal_value_max == mpt_pkg::UNCAL_VALUE) begin
      init_turn = mpt_pkg::UNCAL_TURN;
    end else if (cfg_i.cal_turn_min == cfg_i.cal_turn_max) begin
      init_turn = cfg_i.cal_turn_min;
    end else if (cfg_i.cal_turn_min < cfg_i.cal_turn_max) begin
      if (sample_i >= cfg_i.cal_value_min) begin
        init_turn = cfg_i.cal_turn_min;
      end else if (sample_i <= cfg_i.cal_value_max) begin
        init_turn = cfg_i.cal_turn_max;
      end
    end else begin
      if (sample_i <= cfg_i.cal_value_min) begin
        init_turn = cfg_i.cal_turn_min;
      end else if (sample_i >= cfg_i.cal_value_max) begin
        init_turn = cfg_i.cal_turn_max;
      end
    end
  end

  assign moved = upward_q ? (cur_comb_i - ref_q) : (ref_q - cur_comb_i);
  assign fire  = arm_q && (ref_q != '0) &&
                 (moved > {{(mpt_pkg::COMB_W-mpt_pkg::POS_W){1'b0}}, cfg_i.blink_hysteresis});

  always_comb begin
    pos_d    = pos_q;
    turn_d   = turn_q;
    init_d   = init_q;
    upward_d = upward_q;
    ref_d    = ref_q;
    arm_d    = arm_q;
    blink_d  = blink_q;
    if (ctl_i.upd) begin
      blink_d = 1'b0;
      arm_d   = 1'b0;
      case (mode_i)
        mpt_pkg::MODE_SAMPLE: begin
          pos_d = sample_i;
          if (init_q) begin
            arm_d = 1'b1;
            if (wrap) begin
              upward_d = !up;
              ref_d    = mpt_pkg::combine(turn_q, pos_q, TC);
              turn_d   = up ? (turn_q - 1'b1) : (turn_q + 1'b1);
            end
          end else begin
            turn_d = init_turn;
            init_d = 1'b1;
          end
        end
        mpt_pkg::MODE_ACTIVATE:   init_d = 1'b1;
        mpt_pkg::MODE_DEACTIVATE: init_d = 1'b0;
        default: ;
      endcase
    end
    if (ctl_i.chk && fire) begin
      blink_d = 1'b1;
      ref_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      turn_q   <= '0;
      init_q   <= 1'b0;
      upward_q <= 1'b0;
      ref_q    <= '0;
      arm_q    <= 1'b0;
      blink_q  <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      turn_q   <= turn_d;
      init_q   <= init_d;
      upward_q <= upward_d;
      ref_q    <= ref_d;
      arm_q    <= arm_d;
      blink_q  <= blink_d;
    end
  end

  assign pos_o   = pos_q;
  assign turn_o  = turn_q;
  assign blink_o = blink_q;

endmodule

`default_nettype wire

// File: sv/multiturn_position_tracker_unit.sv
// Top level of the multi-turn position tracker: config registers, sequencer, output register.
// Depends on mpt_pkg, mpt_tracker and mpt_divider.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o, fields mode_i, sample_i): one transfer
//    per step. Mode 0 feeds a sample, 1 activates, 2 deactivates, 3 changes nothing.
//  - Output channel (out_valid_o / out_stall_i): exactly one result per input transfer,
//    carrying position, turn, percent between the calibrated ends and the blink pulse.
//  - Config port (cfg_we_i, cfg_idx_i, cfg_wdata_i): write registers 0..5 while idle;
//    other indexes are ignored.
//  - Sequence: after the input transfer the sequencer steps through state update, combine,
//    end ordering, offset and scale, then the divide step (14 quotient bits, one per
//    cycle, until the divider finishes), then loads the output register, after which
//    out_valid_o rises. The sequencer returns to idle to accept the next item.
//  - The input is stalled while an item is in flight. A finished result sits in the
//    output register; the next item is accepted meanwhile, and its result waits in the
//    final step until the register is taken.
//  - Reset clears state, returns config registers to their reset values and drops
//    out_valid_o; the first sample afterwards sets the turn from calibration.
`default_nettype none

module multiturn_position_tracker_unit #(
  parameter int TURN_COUNTS = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mpt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mpt_pkg::POS_W-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    mode_i,
  input  wire logic [mpt_pkg::POS_W-1:0]     sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [mpt_pkg::POS_W-1:0]          cur_position_o,
  output logic [mpt_pkg::POS_W-1:0]          cur_turn_o,
  output logic [mpt_pkg::PCT_W-1:0]          percent_hundredths_o,
  output logic                               zero_blink_o
);

  localparam logic [mpt_pkg::POS_W:0] TC = (mpt_pkg::POS_W+1)'(TURN_COUNTS);

  mpt_pkg::mpt_state_e  state_q, state_d;
  mpt_pkg::mpt_cfg_t    cfg_q, cfg_d;
  mpt_pkg::mpt_trk_ctl_t trk_ctl;

  logic [1:0]                 mode_q;
  logic [mpt_pkg::POS_W-1:0]  sample_q;
  logic [mpt_pkg::POS_W-1:0]  trk_pos, trk_turn;
  logic                       trk_blink;

  logic [mpt_pkg::COMB_W-1:0] cur_q, open_q, close_q, lo_q, hi_q, diff_q, den_q;
  logic                       rev_q, below_q, above_q;
  logic [mpt_pkg::NUM_W-1:0]  num;
  logic                       div_start, div_busy;
  logic [mpt_pkg::PCT_W-1:0]  quot, pct_raw, pct;

  logic                       in_xfer, out_free, out_load;
  logic                       out_valid_q, out_valid_d;
  logic [mpt_pkg::POS_W-1:0]  out_pos_q, out_turn_q;
  logic [mpt_pkg::PCT_W-1:0]  out_pct_q;
  logic                       out_blink_q;

  // ---- Configuration registers ----
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mpt_pkg::REG_CAL_VALUE_MIN:    cfg_d.cal_value_min    = cfg_wdata_i;
        mpt_pkg::REG_CAL_VALUE_MAX:    cfg_d.cal_value_max    = cfg_wdata_i;
        mpt_pkg::REG_CAL_TURN_MIN:     cfg_d.cal_turn_min     = cfg_wdata_i;
        mpt_pkg::REG_CAL_TURN_MAX:     cfg_d.cal_turn_max     = cfg_wdata_i;
        mpt_pkg::REG_WRAP_THRESHOLD:   cfg_d.wrap_threshold   = cfg_wdata_i;
        mpt_pkg::REG_BLINK_HYSTERESIS: cfg_d.blink_hysteresis = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_value_min    <= mpt_pkg::UNCAL_VALUE;
      cfg_q.cal_value_max    <= mpt_pkg::UNCAL_VALUE;
      cfg_q.cal_turn_min     <= '0;
      cfg_q.cal_turn_max     <= '0;
      cfg_q.wrap_threshold   <= mpt_pkg::RST_WRAP_THRESHOLD;
      cfg_q.blink_hysteresis <= mpt_pkg::RST_BLINK_HYSTERESIS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---- Sequencer ----
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mpt_pkg::ST_IDLE:    if (in_valid_i) state_d = mpt_pkg::ST_UPDATE;
      mpt_pkg::ST_UPDATE:  state_d = mpt_pkg::ST_COMBINE;
      mpt_pkg::ST_COMBINE: state_d = mpt_pkg::ST_ORDER;
      mpt_pkg::ST_ORDER:   state_d = mpt_pkg::ST_OFFSET;
      mpt_pkg::ST_OFFSET:  state_d = mpt_pkg::ST_SCALE;
      mpt_pkg::ST_SCALE:   state_d = mpt_pkg::ST_DIVIDE;
      mpt_pkg::ST_DIVIDE:  if (!div_busy) state_d = mpt_pkg::ST_FINISH;
      mpt_pkg::ST_FINISH:  if (out_free) state_d = mpt_pkg::ST_IDLE;
      default:             state_d = mpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    trk_ctl.upd = 1'b0;
    trk_ctl.chk = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      mpt_pkg::ST_IDLE:   in_stall_o  = 1'b0;
      mpt_pkg::ST_UPDATE: trk_ctl.upd = 1'b1;
      mpt_pkg::ST_ORDER:  trk_ctl.chk = 1'b1;
      mpt_pkg::ST_SCALE:  div_start   = 1'b1;
      mpt_pkg::ST_FINISH: out_load    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---- Tracker state ----
  mpt_tracker #(
    .TURN_COUNTS(TURN_COUNTS)
  ) u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (trk_ctl),
    .cfg_i     (cfg_q),
    .mode_i    (mode_q),
    .sample_i  (sample_q),
    .cur_comb_i(cur_q),
    .pos_o     (trk_pos),
    .turn_o    (trk_turn),
    .blink_o   (trk_blink)
  );

  // ---- Percent datapath ----
  // Hold the input item; combine, order the ends, take offsets, then scale by 10000
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q   <= mode_i;
      sample_q <= sample_i;
    end
    if (state_q == mpt_pkg::ST_COMBINE) begin
      cur_q   <= mpt_pkg::combine(trk_turn, trk_pos, TC);
      open_q  <= mpt_pkg::combine(cfg_q.cal_turn_min, cfg_q.cal_value_min, TC);
      close_q <= mpt_pkg::combine(cfg_q.cal_turn_max, cfg_q.cal_value_max, TC);
    end
    if (state_q == mpt_pkg::ST_ORDER) begin
      rev_q <= (open_q > close_q);
      lo_q  <= (open_q > close_q) ? close_q : open_q;
      hi_q  <= (open_q > close_q) ? open_q : close_q;
    end
    if (state_q == mpt_pkg::ST_OFFSET) begin
      diff_q  <= cur_q - lo_q;
      den_q   <= hi_q - lo_q;
      below_q <= (cur_q <= lo_q);
      above_q <= (cur_q >= hi_q);
    end
  end

  assign num = {{mpt_pkg::PCT_W{1'b0}}, diff_q} *
               {{mpt_pkg::COMB_W{1'b0}}, mpt_pkg::PCT_FULL};

  mpt_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (den_q),
    .busy_o (div_busy),
    .quot_o (quot)
  );

  // Clamp outside the span, invert when the ends are reversed
  assign pct_raw = below_q ? '0 : (above_q ? mpt_pkg::PCT_FULL : quot);
  assign pct     = rev_q ? (mpt_pkg::PCT_FULL - pct_raw) : pct_raw;

  // ---- Output register ----
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pos_q   <= trk_pos;
      out_turn_q  <= trk_turn;
      out_pct_q   <= pct;
      out_blink_q <= trk_blink;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign cur_position_o       = out_pos_q;
  assign cur_turn_o           = out_turn_q;
  assign percent_hundredths_o = out_pct_q;
  assign zero_blink_o         = out_blink_q;

endmodule

`default_nettype wire

// File: bench/position_tracker_checker.sv
`timescale 1ns / 100ps
// Checker for the multi-turn position tracker: follows the config port and both channels,
// predicts each result and compares it field by field. Depends on mpt_pkg.
module position_tracker_checker #(
  parameter int TURN_COUNTS = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mpt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mpt_pkg::POS_W-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire logic [1:0]                    mode_i,
  input  wire logic [mpt_pkg::POS_W-1:0]     sample_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic [mpt_pkg::POS_W-1:0]     cur_position_i,
  input  wire logic [mpt_pkg::POS_W-1:0]     cur_turn_i,
  input  wire logic [mpt_pkg::PCT_W-1:0]     percent_i,
  input  wire logic                          zero_blink_i,
  output int                                 outstanding_o,
  output int                                 fail_count_o
);

  typedef logic [mpt_pkg::POS_W-1:0]  word_t;
  typedef logic [mpt_pkg::COMB_W-1:0] comb_t;
  typedef logic [mpt_pkg::PCT_W-1:0]  pct_t;

  typedef struct packed {
    word_t position;
    word_t turn;
    pct_t  pct;
    logic  blink;
  } reading_t;

  word_t     cal_vmin, cal_vmax, cal_tmin, cal_tmax, wrap_thr, hyst;
  word_t     last_pos, turn_cnt;
  logic      tracking, blink_up;
  comb_t     blink_ref;
  reading_t  readings_due[$];

  function automatic comb_t joined(input word_t turn, input word_t pos);
    logic [63:0] prod;
    prod = 64'(turn) * 64'(TURN_COUNTS);
    return prod[mpt_pkg::COMB_W-1:0] + comb_t'(pos);
  endfunction

  function automatic word_t gap16(input word_t a, input word_t b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // First sample's turn: UNCAL_TURN if uncalibrated, else a calibrated end, nearest as fallback.
  function automatic word_t turn_at_start(input word_t pos);
    if (cal_vmin == mpt_pkg::UNCAL_VALUE || cal_vmax == mpt_pkg::UNCAL_VALUE)
      return mpt_pkg::UNCAL_TURN;
    if (cal_tmin == cal_tmax) return cal_tmin;
    if (cal_tmin < cal_tmax) begin
      if (pos >= cal_vmin) return cal_tmin;
      if (pos <= cal_vmax) return cal_tmax;
    end else begin
      if (pos <= cal_vmin) return cal_tmin;
      if (pos >= cal_vmax) return cal_tmax;
    end
    return (gap16(pos, cal_vmin) < gap16(pos, cal_vmax)) ? cal_tmin : cal_tmax;
  endfunction

  function automatic pct_t span_fraction();
    comb_t       open_end, close_end, lo, hi, here;
    logic        flipped;
    logic [63:0] frac;
    open_end  = joined(cal_tmin, cal_vmin);
    close_end = joined(cal_tmax, cal_vmax);
    flipped   = open_end > close_end;
    lo        = flipped ? close_end : open_end;
    hi        = flipped ? open_end : close_end;
    here      = joined(turn_cnt, last_pos);
    if (here <= lo) frac = 64'd0;
    else if (here >= hi) frac = 64'd10000;
    else frac = (64'(here - lo) * 64'd10000) / 64'(hi - lo);
    if (flipped) frac = 64'd10000 - frac;
    return frac[mpt_pkg::PCT_W-1:0];
  endfunction

  // Fire and disarm once the position has moved past the hysteresis band.
  function automatic logic blink_due();
    comb_t here, moved;
    if (blink_ref == '0) return 1'b0;
    here  = joined(turn_cnt, last_pos);
    moved = blink_up ? here - blink_ref : blink_ref - here;
    if (moved > comb_t'(hyst)) begin
      blink_ref = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic reading_t track_step(input logic [1:0] mode, input word_t smp);
    reading_t r;
    logic     fired;
    fired = 1'b0;
    case (mode)
      mpt_pkg::MODE_SAMPLE: begin
        if (tracking) begin
          if (smp > last_pos) begin
            if (word_t'(smp - last_pos) >= wrap_thr) begin
              blink_up  = 1'b0;
              blink_ref = joined(turn_cnt, last_pos);
              turn_cnt  = turn_cnt - 1'b1;
            end
          end else if (word_t'(last_pos - smp) >= wrap_thr) begin
            blink_up  = 1'b1;
            blink_ref = joined(turn_cnt, last_pos);
            turn_cnt  = turn_cnt + 1'b1;
          end
          last_pos = smp;
          fired    = blink_due();
        end else begin
          last_pos = smp;
          turn_cnt = turn_at_start(smp);
          tracking = 1'b1;
        end
      end
      mpt_pkg::MODE_ACTIVATE:   tracking = 1'b1;
      mpt_pkg::MODE_DEACTIVATE: tracking = 1'b0;
      default: ;
    endcase
    r.position = last_pos;
    r.turn     = turn_cnt;
    r.pct      = span_fraction();
    r.blink    = fired;
    return r;
  endfunction

  task automatic compare(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // Retire results before taking new transfers: a result never belongs to an item
  // accepted on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    reading_t want;
    if (!rst_ni) begin
      cal_vmin  = mpt_pkg::UNCAL_VALUE;
      cal_vmax  = mpt_pkg::UNCAL_VALUE;
      cal_tmin  = '0;
      cal_tmax  = '0;
      wrap_thr  = mpt_pkg::RST_WRAP_THRESHOLD;
      hyst      = mpt_pkg::RST_BLINK_HYSTERESIS;
      last_pos  = '0;
      turn_cnt  = '0;
      tracking  = 1'b0;
      blink_ref = '0;
      blink_up  = 1'b0;
      readings_due.delete();
      fail_count_o = 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (readings_due.size() == 0) begin
          $error("result with nothing expected: position %0d turn %0d",
                 cur_position_i, cur_turn_i);
          fail_count_o++;
        end else begin
          want = readings_due.pop_front();
          compare("cur_position", 32'(want.position), 32'(cur_position_i));
          compare("cur_turn", 32'(want.turn), 32'(cur_turn_i));
          compare("percent_hundredths", 32'(want.pct), 32'(percent_i));
          compare("zero_blink", 32'(want.blink), 32'(zero_blink_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mpt_pkg::REG_CAL_VALUE_MIN:    cal_vmin = cfg_wdata_i;
          mpt_pkg::REG_CAL_VALUE_MAX:    cal_vmax = cfg_wdata_i;
          mpt_pkg::REG_CAL_TURN_MIN:     cal_tmin = cfg_wdata_i;
          mpt_pkg::REG_CAL_TURN_MAX:     cal_tmax = cfg_wdata_i;
          mpt_pkg::REG_WRAP_THRESHOLD:   wrap_thr = cfg_wdata_i;
          mpt_pkg::REG_BLINK_HYSTERESIS: hyst     = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) readings_due.push_back(track_step(mode_i, sample_i));
      outstanding_o <= readings_due.size();
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Top of the bench for multiturn_position_tracker_unit: clock, reset, stimulus and verdict.
// Depends on mpt_pkg, the tracker RTL and position_tracker_checker.
module tb;

  typedef logic [mpt_pkg::POS_W-1:0] word_t;

  localparam int TC = 4096;
  // Mode with no effect, and a config index that the block ignores.
  localparam logic [1:0]                    MODE_NONE     = 2'd3;
  localparam logic [mpt_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [mpt_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  word_t                         cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic [1:0]                    in_mode = mpt_pkg::MODE_SAMPLE;
  word_t                         in_sample = '0;
  logic                          out_stall = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  word_t                         cur_position, cur_turn;
  logic [mpt_pkg::PCT_W-1:0]     percent;
  logic                          zero_blink;
  int                            outstanding, fail_count;

  // Idling controls for the sender and the receiver.
  logic send_gaps = 1'b1;
  logic rx_gaps   = 1'b1;
  logic hold_req  = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  multiturn_position_tracker_unit #(.TURN_COUNTS(TC)) dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_we_i             (cfg_we),
    .cfg_idx_i            (cfg_idx),
    .cfg_wdata_i          (cfg_wdata),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .mode_i               (in_mode),
    .sample_i             (in_sample),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .cur_position_o       (cur_position),
    .cur_turn_o           (cur_turn),
    .percent_hundredths_o (percent),
    .zero_blink_o         (zero_blink)
  );

  position_tracker_checker #(.TURN_COUNTS(TC)) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .mode_i         (in_mode),
    .sample_i       (in_sample),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .cur_position_i (cur_position),
    .cur_turn_i     (cur_turn),
    .percent_i      (percent),
    .zero_blink_i   (zero_blink),
    .outstanding_o  (outstanding),
    .fail_count_o   (fail_count)
  );

  // Offer one item and return on the edge that takes it. Valid stays high on
  // return, so back-to-back items never toggle it within one step.
  task automatic offer(input logic [1:0] m, input word_t s);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_mode   <= m;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every result has been taken; each item yields
  // exactly one result, so the block is idle once nothing is outstanding.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Load all six registers on consecutive edges; only while idle.
  task automatic write_regs(input word_t vmin, input word_t vmax,
                            input word_t tmin, input word_t tmax,
                            input word_t wrap, input word_t hys);
    cfg_we    <= 1'b1;
    cfg_idx   <= mpt_pkg::REG_CAL_VALUE_MIN;
    cfg_wdata <= vmin;
    @(posedge clk);
    cfg_idx   <= mpt_pkg::REG_CAL_VALUE_MAX;
    cfg_wdata <= vmax;
    @(posedge clk);
    cfg_idx   <= mpt_pkg::REG_CAL_TURN_MIN;
    cfg_wdata <= tmin;
    @(posedge clk);
    cfg_idx   <= mpt_pkg::REG_CAL_TURN_MAX;
    cfg_wdata <= tmax;
    @(posedge clk);
    cfg_idx   <= mpt_pkg::REG_WRAP_THRESHOLD;
    cfg_wdata <= wrap;
    @(posedge clk);
    cfg_idx   <= mpt_pkg::REG_BLINK_HYSTERESIS;
    cfg_wdata <= hys;
    @(posedge clk);
    // Poke an unused index too; the block must ignore it.
    cfg_idx   <= CFG_IDX_SPARE;
    cfg_wdata <= word_t'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: random stall bursts, quiet stretches, and one long hold-off on request.
  initial begin : receiver
    int held;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (held = 0; held < 400; held++) @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int    angle, pick;
    word_t tbase;
    angle = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, uncalibrated: no-op before tracking, first sample takes turn 0x20,
    // wraps both ways, a sample above one turn, and a jump exactly at the threshold.
    offer(MODE_NONE, 16'h1234);
    offer(mpt_pkg::MODE_SAMPLE, 16'd100);
    offer(mpt_pkg::MODE_SAMPLE, 16'd4095);
    offer(mpt_pkg::MODE_SAMPLE, 16'd0);
    offer(mpt_pkg::MODE_SAMPLE, 16'hFFFF);
    offer(mpt_pkg::MODE_SAMPLE, 16'd0);
    offer(mpt_pkg::MODE_DEACTIVATE, 16'hFFFF);
    offer(mpt_pkg::MODE_ACTIVATE, 16'h0000);
    offer(mpt_pkg::MODE_SAMPLE, 16'd2047);
    offer(mpt_pkg::MODE_SAMPLE, 16'd4095);
    offer(mpt_pkg::MODE_DEACTIVATE, 16'd0);
    offer(mpt_pkg::MODE_SAMPLE, 16'd3000);
    drain();

    // Both ends at zero: a wrap from the origin stays disarmed and the turn underflows.
    write_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd2048, 16'd64);
    offer(mpt_pkg::MODE_DEACTIVATE, 16'd0);
    offer(mpt_pkg::MODE_SAMPLE, 16'd0);
    offer(mpt_pkg::MODE_SAMPLE, 16'd4000);
    offer(mpt_pkg::MODE_SAMPLE, 16'd0);
    drain();

    // Zero thresholds: every sample wraps, even a repeated one.
    write_regs(16'd4095, 16'd0, 16'd3, 16'd9, 16'd0, 16'd0);
    offer(mpt_pkg::MODE_DEACTIVATE, 16'd0);
    offer(mpt_pkg::MODE_SAMPLE, 16'd50);
    offer(mpt_pkg::MODE_SAMPLE, 16'd50);
    offer(mpt_pkg::MODE_SAMPLE, 16'd51);
    offer(MODE_NONE, 16'hA5A5);
    drain();

    // Random phases, one setting each; the last one runs without idling.
    for (int ph = 0; ph < 6; ph++) begin
      tbase = word_t'($urandom_range(8, 40));
      case (ph)
        1:       write_regs(word_t'($urandom_range(0, 4095)), word_t'($urandom_range(0, 4095)),
                            tbase + word_t'($urandom_range(1, 6)), tbase,
                            word_t'($urandom_range(1500, 2600)),
                            word_t'($urandom_range(0, 200)));
        2:       write_regs(16'hFFFF, 16'hFFFE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        3:       write_regs(16'd0, 16'd4095, 16'd0, 16'hFFFF, 16'd1, 16'd0);
        4:       write_regs(word_t'($urandom), word_t'($urandom), word_t'($urandom),
                            word_t'($urandom), word_t'($urandom), word_t'($urandom));
        default: write_regs(word_t'($urandom_range(0, 4095)), word_t'($urandom_range(0, 4095)),
                            tbase, tbase + word_t'($urandom_range(1, 6)),
                            word_t'($urandom_range(1500, 2600)),
                            word_t'($urandom_range(0, 200)));
      endcase
      if (ph == 5) begin
        send_gaps = 1'b0;
        rx_gaps   = 1'b0;
      end
      // Start each phase from a fresh initialization under the new calibration.
      offer(mpt_pkg::MODE_DEACTIVATE, word_t'($urandom));
      for (int n = 0; n < 270; n++) begin
        if (ph == 1 && n == 100) hold_req = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 3) offer(mpt_pkg::MODE_DEACTIVATE, word_t'($urandom));
        else if (pick < 5) offer(mpt_pkg::MODE_ACTIVATE, word_t'($urandom));
        else if (pick < 7) offer(MODE_NONE, word_t'($urandom));
        else if (pick < 12) offer(mpt_pkg::MODE_SAMPLE, word_t'($urandom));
        else begin
          // Walk the angle smoothly so that wraps happen at the turn boundary.
          angle = (angle + int'($urandom_range(0, 600)) - 300) & (TC - 1);
          offer(mpt_pkg::MODE_SAMPLE, angle[mpt_pkg::POS_W-1:0]);
        end
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #1500000;
    $display("tb: errors");
    $finish;
  end

endmodule
